FILE: sv/hctt_pkg.sv
// ----------------------------------------------------------------------------
// hctt_pkg
// Shared types and constants for the hot/cold tier co-access tracker.
// ----------------------------------------------------------------------------
package hctt_pkg;

    localparam int RING_LEN = 4;
    localparam int HINT_MAX = 3;

    localparam logic [1:0] CMD_ACCESS    = 2'd0;
    localparam logic [1:0] CMD_REBALANCE = 2'd1;

    localparam logic [1:0] TIER_NONE = 2'd0;
    localparam logic [1:0] TIER_WARM = 2'd1;
    localparam logic [1:0] TIER_HOT  = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE_ACCESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE_REBALANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMOTE_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_WINDOW        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HINT_MINIMUM      = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] item_id;
    } hctt_in_t;

    typedef struct packed {
        logic [1:0]  tier;
        logic        hint_valid;
        logic [31:0] hint_id;
        logic        last;
    } hctt_out_t;

    // one hot or warm table entry
    typedef struct packed {
        logic [31:0] id;
        logic [15:0] count;
        logic [31:0] last_turn;
    } ent_t;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE,
        S_A_PAIR, S_A_SRD, S_A_SCHK, S_A_ALLOCA, S_A_ALLOCB, S_A_PAIRCHK,
        S_A_BRD1, S_A_BWR1, S_A_BRD2, S_A_BWR2,
        S_A_HRD, S_A_HCHK, S_A_WRD, S_A_WCHK, S_A_WMOVE,
        S_R1_RD, S_R1_CHK, S_R1_MOVE, S_R2_RD, S_R2_CHK, S_R2_MOVE,
        S_R3_RD, S_R3_CHK,
        S_Q_HRD, S_Q_HCHK, S_Q_WRD, S_Q_WCHK, S_Q_SRD, S_Q_SCHK,
        S_Q_ROUND, S_Q_JRD, S_Q_JCHK, S_Q_PICK,
        S_EMIT
    } state_t;

    function automatic logic [15:0] count_inc(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic logic [7:0] pair_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // count * 3 / 4
    function automatic logic [15:0] count_decay(input logic [15:0] c);
        logic [17:0] p;
        p = 18'(c) + 18'({c, 1'b0});
        return p[17:2];
    endfunction

endpackage

FILE: sv/hctt_ram.sv
// ----------------------------------------------------------------------------
// hctt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/hot_cold_tier_coaccess_tracker_unit.sv
// ----------------------------------------------------------------------------
// hot_cold_tier_coaccess_tracker_unit
// Hot/warm id tracker with a co-access matrix and prefetch hints.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one command per transaction:
// access, rebalance, or query for any other command code. Output channel
// (out_valid/out_stall/out_data) returns one to three result transactions per
// command, the final one with last set. One command is worked at a time;
// in_stall is high while busy. All tables sit in single-read-port RAMs with a
// registered read, and every scan step is a read state followed by a
// check/write state.
// After reset all SLOT_DEPTH*SLOT_DEPTH pair matrix entries (1024 by default)
// are cleared with in_stall high; config writes are taken meanwhile.
// An output register decouples the sides: a command may be accepted while
// its predecessor's last result still waits. While out_stall is high the
// held result stays put and the unit waits before loading the next one.
// ----------------------------------------------------------------------------
module hot_cold_tier_coaccess_tracker_unit #(
    parameter int HOT_DEPTH  = 16,
    parameter int WARM_DEPTH = 64,
    parameter int SLOT_DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  hctt_pkg::hctt_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output hctt_pkg::hctt_out_t                 out_data,
    input  logic                                cfg_we,
    input  logic [hctt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hctt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import hctt_pkg::*;

    localparam int HF_W = $clog2(HOT_DEPTH + 1);
    localparam int WF_W = $clog2(WARM_DEPTH + 1);
    localparam int SF_W = $clog2(SLOT_DEPTH + 1);
    localparam int HA_W = (HOT_DEPTH > 1) ? $clog2(HOT_DEPTH) : 1;
    localparam int WA_W = (WARM_DEPTH > 1) ? $clog2(WARM_DEPTH) : 1;
    localparam int SA_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int PD   = SLOT_DEPTH * SLOT_DEPTH;
    localparam int PA_W = $clog2(PD);
    localparam int ENT_W = $bits(ent_t);

    // configuration
    logic [15:0] poa_reg, por_reg, dcl_reg, age_reg;
    logic [7:0]  hmin_reg;

    // control state
    state_t           state_reg, state_next;
    logic [31:0]      turn_reg, turn_next;
    logic [31:0]      ring_reg [RING_LEN];
    logic [31:0]      ring_next [RING_LEN];
    logic [1:0]       rp_reg, rp_next;
    logic [HF_W-1:0]  hot_fill_reg, hot_fill_next;
    logic [WF_W-1:0]  warm_fill_reg, warm_fill_next;
    logic [SF_W-1:0]  slot_fill_reg, slot_fill_next;
    logic [PA_W-1:0]  clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;

    // working registers
    logic [31:0]      id_reg, id_next;
    logic [2:0]       ri_reg, ri_next;
    logic [SF_W-1:0]  sidx_reg, sidx_next;
    logic [SF_W-1:0]  jidx_reg, jidx_next;
    logic [SF_W-1:0]  sa_reg, sa_next;
    logic [SF_W-1:0]  sb_reg, sb_next;
    logic [SF_W-1:0]  qslot_reg, qslot_next;
    logic             sa_ok_reg, sa_ok_next;
    logic             sb_ok_reg, sb_ok_next;
    logic [HF_W-1:0]  hidx_reg, hidx_next;
    logic [HF_W-1:0]  hrem_reg, hrem_next;
    logic [WF_W-1:0]  widx_reg, widx_next;
    logic [WF_W-1:0]  wrem_reg, wrem_next;
    logic [31:0]      limit_reg, limit_next;
    logic [1:0]       tier_reg, tier_next;
    logic [31:0]      hint_reg [HINT_MAX];
    logic [31:0]      hint_next [HINT_MAX];
    logic [1:0]       nh_reg, nh_next;
    logic [1:0]       ek_reg, ek_next;
    logic [7:0]       best_reg, best_next;
    logic [31:0]      best_id_reg, best_id_next;
    logic             bi_ok_reg, bi_ok_next;
    hctt_out_t        out_data_reg, out_data_next;

    // memory ports
    logic             h_we, w_we, s_we, p_we;
    logic [HA_W-1:0]  h_waddr, h_raddr;
    logic [WA_W-1:0]  w_waddr, w_raddr;
    logic [SA_W-1:0]  s_waddr, s_raddr;
    logic [PA_W-1:0]  p_waddr, p_raddr;
    ent_t             h_wdata, w_wdata, h_rd, w_rd;
    logic [ENT_W-1:0] h_rdata, w_rdata;
    logic [31:0]      s_wdata, s_rdata;
    logic [7:0]       p_wdata, p_rdata;

    // shared conditions
    logic [31:0]      prev;
    logic             pair_needed;
    logic [HF_W-1:0]  hf_dec, hrem_dec;
    logic [WF_W-1:0]  wf_dec, wrem_dec;
    logic [15:0]      wc_inc;
    logic             a_promote, r_demote, r_promote, hint_dup, hint_take;
    logic             hot_room, warm_room, slot_room, out_free, emit_last;

    function automatic logic [PA_W-1:0] pair_addr(input logic [SF_W-1:0] a,
                                                  input logic [SF_W-1:0] b);
        return PA_W'(PA_W'(a) * PA_W'(SLOT_DEPTH) + PA_W'(b));
    endfunction

    hctt_ram #(.WIDTH(ENT_W), .DEPTH(HOT_DEPTH)) u_hot_ram (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    hctt_ram #(.WIDTH(ENT_W), .DEPTH(WARM_DEPTH)) u_warm_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    hctt_ram #(.WIDTH(32), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    hctt_ram #(.WIDTH(8), .DEPTH(PD)) u_pair_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    assign h_rd = ent_t'(h_rdata);
    assign w_rd = ent_t'(w_rdata);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign prev        = ring_reg[ri_reg[1:0]];
    assign pair_needed = (prev != 32'd0) && (prev != id_reg);
    assign hf_dec      = hot_fill_reg - HF_W'(1);
    assign hrem_dec    = hrem_reg - HF_W'(1);
    assign wf_dec      = warm_fill_reg - WF_W'(1);
    assign wrem_dec    = wrem_reg - WF_W'(1);
    assign hot_room    = (hot_fill_reg < HF_W'(HOT_DEPTH));
    assign warm_room   = (warm_fill_reg < WF_W'(WARM_DEPTH));
    assign slot_room   = (slot_fill_reg < SF_W'(SLOT_DEPTH));
    assign wc_inc      = count_inc(w_rd.count);
    assign a_promote   = (wc_inc > poa_reg) && hot_room;
    assign r_demote    = (h_rd.last_turn < limit_reg) && (h_rd.count < dcl_reg);
    assign r_promote   = (w_rd.count > por_reg) && hot_room;
    assign hint_dup    = ((nh_reg > 2'd0) && (hint_reg[0] == s_rdata))
                      || ((nh_reg > 2'd1) && (hint_reg[1] == s_rdata))
                      || ((nh_reg > 2'd2) && (hint_reg[2] == s_rdata));
    assign hint_take   = bi_ok_reg && (best_reg > hmin_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign emit_last   = (nh_reg == 2'd0) || (ek_reg + 2'd1 == nh_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poa_reg  <= 16'd5;
            por_reg  <= 16'd10;
            dcl_reg  <= 16'd3;
            age_reg  <= 16'd100;
            hmin_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROMOTE_ACCESS:    poa_reg  <= cfg_data;
                CFG_PROMOTE_REBALANCE: por_reg  <= cfg_data;
                CFG_DEMOTE_LIMIT:      dcl_reg  <= cfg_data;
                CFG_AGE_WINDOW:        age_reg  <= cfg_data;
                CFG_HINT_MINIMUM:      hmin_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_reg == PA_W'(PD - 1)) state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                begin
                    unique case (in_data.cmd)
                        CMD_ACCESS:    state_next = S_A_PAIR;
                        CMD_REBALANCE: state_next = S_R1_RD;
                        default:       state_next = S_Q_HRD;
                    endcase
                end
            S_A_PAIR:
                if (ri_reg == 3'(RING_LEN)) state_next = S_A_HRD;
                else if (pair_needed) state_next = S_A_SRD;
            S_A_SRD:
                state_next = (sidx_reg == slot_fill_reg) ? S_A_ALLOCA : S_A_SCHK;
            S_A_SCHK:    state_next = S_A_SRD;
            S_A_ALLOCA:  state_next = S_A_ALLOCB;
            S_A_ALLOCB:  state_next = S_A_PAIRCHK;
            S_A_PAIRCHK:
                state_next = (sa_ok_reg && sb_ok_reg) ? S_A_BRD1 : S_A_PAIR;
            S_A_BRD1:    state_next = S_A_BWR1;
            S_A_BWR1:    state_next = S_A_BRD2;
            S_A_BRD2:    state_next = S_A_BWR2;
            S_A_BWR2:    state_next = S_A_PAIR;
            S_A_HRD:
                state_next = (hidx_reg == hot_fill_reg) ? S_A_WRD : S_A_HCHK;
            S_A_HCHK:
                state_next = (h_rd.id == id_reg) ? S_EMIT : S_A_HRD;
            S_A_WRD:
                state_next = (widx_reg == warm_fill_reg) ? S_EMIT : S_A_WCHK;
            S_A_WCHK:
                if (w_rd.id == id_reg) state_next = a_promote ? S_A_WMOVE : S_EMIT;
                else state_next = S_A_WRD;
            S_A_WMOVE:   state_next = S_EMIT;
            S_R1_RD:
                state_next = (hrem_reg == '0) ? S_R2_RD : S_R1_CHK;
            S_R1_CHK:
                state_next = r_demote ? S_R1_MOVE : S_R1_RD;
            S_R1_MOVE:   state_next = S_R1_RD;
            S_R2_RD:
                state_next = (wrem_reg == '0) ? S_R3_RD : S_R2_CHK;
            S_R2_CHK:
                state_next = r_promote ? S_R2_MOVE : S_R2_RD;
            S_R2_MOVE:   state_next = S_R2_RD;
            S_R3_RD:
                state_next = (widx_reg == warm_fill_reg) ? S_EMIT : S_R3_CHK;
            S_R3_CHK:    state_next = S_R3_RD;
            S_Q_HRD:
                state_next = (hidx_reg == hot_fill_reg) ? S_Q_WRD : S_Q_HCHK;
            S_Q_HCHK:
                state_next = (h_rd.id == id_reg) ? S_Q_SRD : S_Q_HRD;
            S_Q_WRD:
                state_next = (widx_reg == warm_fill_reg) ? S_Q_SRD : S_Q_WCHK;
            S_Q_WCHK:
                state_next = (w_rd.id == id_reg) ? S_Q_SRD : S_Q_WRD;
            S_Q_SRD:
                state_next = (sidx_reg == slot_fill_reg) ? S_EMIT : S_Q_SCHK;
            S_Q_SCHK:
                state_next = (s_rdata == id_reg) ? S_Q_ROUND : S_Q_SRD;
            S_Q_ROUND:
                state_next = (nh_reg == 2'(HINT_MAX)) ? S_EMIT : S_Q_JRD;
            S_Q_JRD:
                if (jidx_reg == slot_fill_reg) state_next = S_Q_PICK;
                else if (jidx_reg != qslot_reg) state_next = S_Q_JCHK;
            S_Q_JCHK:    state_next = S_Q_JRD;
            S_Q_PICK:
                state_next = hint_take ? S_Q_ROUND : S_EMIT;
            S_EMIT:
                if (out_free && emit_last) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        turn_next      = turn_reg;
        ring_next      = ring_reg;
        rp_next        = rp_reg;
        hot_fill_next  = hot_fill_reg;
        warm_fill_next = warm_fill_reg;
        slot_fill_next = slot_fill_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        id_next        = id_reg;
        ri_next        = ri_reg;
        sidx_next      = sidx_reg;
        jidx_next      = jidx_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        qslot_next     = qslot_reg;
        sa_ok_next     = sa_ok_reg;
        sb_ok_next     = sb_ok_reg;
        hidx_next      = hidx_reg;
        hrem_next      = hrem_reg;
        widx_next      = widx_reg;
        wrem_next      = wrem_reg;
        limit_next     = limit_reg;
        tier_next      = tier_reg;
        hint_next      = hint_reg;
        nh_next        = nh_reg;
        ek_next        = ek_reg;
        best_next      = best_reg;
        best_id_next   = best_id_reg;
        bi_ok_next     = bi_ok_reg;

        h_we = 1'b0; h_waddr = hidx_reg[HA_W-1:0]; h_wdata = h_rd;
        h_raddr = hidx_reg[HA_W-1:0];
        w_we = 1'b0; w_waddr = widx_reg[WA_W-1:0]; w_wdata = w_rd;
        w_raddr = widx_reg[WA_W-1:0];
        s_we = 1'b0; s_waddr = slot_fill_reg[SA_W-1:0]; s_wdata = id_reg;
        s_raddr = sidx_reg[SA_W-1:0];
        p_we = 1'b0; p_waddr = clr_reg; p_wdata = 8'd0;
        p_raddr = pair_addr(sa_reg, sb_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                p_we     = 1'b1;
                clr_next = clr_reg + PA_W'(1);
            end
            S_IDLE:
                if (in_valid)
                begin
                    id_next   = in_data.item_id;
                    nh_next   = 2'd0;
                    ek_next   = 2'd0;
                    tier_next = TIER_NONE;
                    hidx_next = '0;
                    widx_next = '0;
                    sidx_next = '0;
                    ri_next   = 3'd0;
                    hrem_next = hot_fill_reg;
                    limit_next = (turn_reg > 32'(age_reg)) ? turn_reg - 32'(age_reg)
                                                           : 32'd0;
                    if (in_data.cmd == CMD_ACCESS)
                    begin
                        turn_next         = turn_reg + 32'd1;
                        ring_next[rp_reg] = in_data.item_id;
                        rp_next           = rp_reg + 2'd1;
                    end
                end
            S_A_PAIR:
                if (ri_reg != 3'(RING_LEN))
                begin
                    if (pair_needed)
                    begin
                        sidx_next  = '0;
                        sa_ok_next = 1'b0;
                        sb_ok_next = 1'b0;
                    end
                    else
                    begin
                        ri_next = ri_reg + 3'd1;
                    end
                end
            S_A_SCHK:
            begin
                if (s_rdata == id_reg)
                begin
                    sa_next    = sidx_reg;
                    sa_ok_next = 1'b1;
                end
                if (s_rdata == prev)
                begin
                    sb_next    = sidx_reg;
                    sb_ok_next = 1'b1;
                end
                sidx_next = sidx_reg + SF_W'(1);
            end
            S_A_ALLOCA:
                if (!sa_ok_reg && slot_room)
                begin
                    s_we           = 1'b1;
                    s_wdata        = id_reg;
                    sa_next        = slot_fill_reg;
                    sa_ok_next     = 1'b1;
                    slot_fill_next = slot_fill_reg + SF_W'(1);
                end
            S_A_ALLOCB:
                if (!sb_ok_reg && slot_room)
                begin
                    s_we           = 1'b1;
                    s_wdata        = prev;
                    sb_next        = slot_fill_reg;
                    sb_ok_next     = 1'b1;
                    slot_fill_next = slot_fill_reg + SF_W'(1);
                end
            S_A_PAIRCHK:
                if (!(sa_ok_reg && sb_ok_reg)) ri_next = ri_reg + 3'd1;
            S_A_BRD1:
                p_raddr = pair_addr(sa_reg, sb_reg);
            S_A_BWR1:
            begin
                p_we    = 1'b1;
                p_waddr = pair_addr(sa_reg, sb_reg);
                p_wdata = pair_inc(p_rdata);
            end
            S_A_BRD2:
                p_raddr = pair_addr(sb_reg, sa_reg);
            S_A_BWR2:
            begin
                p_we    = 1'b1;
                p_waddr = pair_addr(sb_reg, sa_reg);
                p_wdata = pair_inc(p_rdata);
                ri_next = ri_reg + 3'd1;
            end
            S_A_HCHK:
                if (h_rd.id == id_reg)
                begin
                    h_we      = 1'b1;
                    h_wdata   = '{id: id_reg, count: count_inc(h_rd.count),
                                  last_turn: turn_reg};
                    tier_next = TIER_HOT;
                end
                else
                begin
                    hidx_next = hidx_reg + HF_W'(1);
                end
            S_A_WRD:
                if (widx_reg == warm_fill_reg)
                begin
                    if (warm_room)
                    begin
                        w_we           = 1'b1;
                        w_waddr        = warm_fill_reg[WA_W-1:0];
                        w_wdata        = '{id: id_reg, count: 16'd1,
                                           last_turn: turn_reg};
                        warm_fill_next = warm_fill_reg + WF_W'(1);
                        tier_next      = TIER_WARM;
                    end
                end
            S_A_WCHK:
                if (w_rd.id == id_reg)
                begin
                    if (a_promote)
                    begin
                        h_we           = 1'b1;
                        h_waddr        = hot_fill_reg[HA_W-1:0];
                        h_wdata        = '{id: id_reg, count: wc_inc, last_turn: turn_reg};
                        hot_fill_next  = hot_fill_reg + HF_W'(1);
                        warm_fill_next = wf_dec;
                        w_raddr        = wf_dec[WA_W-1:0];
                        tier_next      = TIER_HOT;
                    end
                    else
                    begin
                        w_we      = 1'b1;
                        w_wdata   = '{id: id_reg, count: wc_inc, last_turn: turn_reg};
                        tier_next = TIER_WARM;
                    end
                end
                else
                begin
                    widx_next = widx_reg + WF_W'(1);
                end
            S_A_WMOVE:
            begin
                // last warm entry fills the hole left by the promoted one
                w_we    = 1'b1;
                w_wdata = w_rd;
            end
            S_R1_RD:
                if (hrem_reg != '0) h_raddr = hrem_dec[HA_W-1:0];
                else wrem_next = warm_fill_reg;
            S_R1_CHK:
                if (r_demote)
                begin
                    if (warm_room)
                    begin
                        w_we           = 1'b1;
                        w_waddr        = warm_fill_reg[WA_W-1:0];
                        w_wdata        = h_rd;
                        warm_fill_next = warm_fill_reg + WF_W'(1);
                    end
                    hot_fill_next = hf_dec;
                    h_raddr       = hf_dec[HA_W-1:0];
                end
                else
                begin
                    hrem_next = hrem_dec;
                end
            S_R1_MOVE:
            begin
                h_we      = 1'b1;
                h_waddr   = hrem_dec[HA_W-1:0];
                h_wdata   = h_rd;
                hrem_next = hrem_dec;
            end
            S_R2_RD:
                if (wrem_reg != '0) w_raddr = wrem_dec[WA_W-1:0];
                else widx_next = '0;
            S_R2_CHK:
                if (r_promote)
                begin
                    h_we           = 1'b1;
                    h_waddr        = hot_fill_reg[HA_W-1:0];
                    h_wdata        = w_rd;
                    hot_fill_next  = hot_fill_reg + HF_W'(1);
                    warm_fill_next = wf_dec;
                    w_raddr        = wf_dec[WA_W-1:0];
                end
                else
                begin
                    wrem_next = wrem_dec;
                end
            S_R2_MOVE:
            begin
                w_we      = 1'b1;
                w_waddr   = wrem_dec[WA_W-1:0];
                w_wdata   = w_rd;
                wrem_next = wrem_dec;
            end
            S_R3_CHK:
            begin
                if (w_rd.last_turn < limit_reg)
                begin
                    w_we    = 1'b1;
                    w_wdata = '{id: w_rd.id, count: count_decay(w_rd.count),
                                last_turn: w_rd.last_turn};
                end
                widx_next = widx_reg + WF_W'(1);
            end
            S_Q_HCHK:
                if (h_rd.id == id_reg) tier_next = TIER_HOT;
                else hidx_next = hidx_reg + HF_W'(1);
            S_Q_WCHK:
                if (w_rd.id == id_reg) tier_next = TIER_WARM;
                else widx_next = widx_reg + WF_W'(1);
            S_Q_SCHK:
                if (s_rdata == id_reg) qslot_next = sidx_reg;
                else sidx_next = sidx_reg + SF_W'(1);
            S_Q_ROUND:
            begin
                jidx_next  = '0;
                best_next  = 8'd0;
                bi_ok_next = 1'b0;
            end
            S_Q_JRD:
                if (jidx_reg != slot_fill_reg)
                begin
                    if (jidx_reg == qslot_reg)
                    begin
                        jidx_next = jidx_reg + SF_W'(1);
                    end
                    else
                    begin
                        s_raddr = jidx_reg[SA_W-1:0];
                        p_raddr = pair_addr(qslot_reg, jidx_reg);
                    end
                end
            S_Q_JCHK:
            begin
                if ((p_rdata > best_reg) && !hint_dup)
                begin
                    best_next    = p_rdata;
                    best_id_next = s_rdata;
                    bi_ok_next   = 1'b1;
                end
                jidx_next = jidx_reg + SF_W'(1);
            end
            S_Q_PICK:
                if (hint_take)
                begin
                    hint_next[nh_reg] = best_id_reg;
                    nh_next           = nh_reg + 2'd1;
                end
            S_EMIT:
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.tier       = tier_reg;
                    out_data_next.hint_valid = (nh_reg != 2'd0);
                    out_data_next.hint_id    = (nh_reg != 2'd0) ? hint_reg[ek_reg] : 32'd0;
                    out_data_next.last       = emit_last;
                    ek_next                  = ek_reg + 2'd1;
                end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            turn_reg      <= 32'd0;
            ring_reg      <= '{default: 32'd0};
            rp_reg        <= 2'd0;
            hot_fill_reg  <= '0;
            warm_fill_reg <= '0;
            slot_fill_reg <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            turn_reg      <= turn_next;
            ring_reg      <= ring_next;
            rp_reg        <= rp_next;
            hot_fill_reg  <= hot_fill_next;
            warm_fill_reg <= warm_fill_next;
            slot_fill_reg <= slot_fill_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        id_reg       <= id_next;
        ri_reg       <= ri_next;
        sidx_reg     <= sidx_next;
        jidx_reg     <= jidx_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        qslot_reg    <= qslot_next;
        sa_ok_reg    <= sa_ok_next;
        sb_ok_reg    <= sb_ok_next;
        hidx_reg     <= hidx_next;
        hrem_reg     <= hrem_next;
        widx_reg     <= widx_next;
        wrem_reg     <= wrem_next;
        limit_reg    <= limit_next;
        tier_reg     <= tier_next;
        hint_reg     <= hint_next;
        nh_reg       <= nh_next;
        ek_reg       <= ek_next;
        best_reg     <= best_next;
        best_id_reg  <= best_id_next;
        bi_ok_reg    <= bi_ok_next;
    end

endmodule

FILE: tb/sv/hot_cold_tier_coaccess_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// hot_cold_tier_coaccess_tracker_unit_tb
// Drives access, rebalance and query transactions with random gaps and stalls,
// predicts tier and hint results in a behavioral copy of the tracker and
// compares every output transaction against it.
// ----------------------------------------------------------------------------
module hot_cold_tier_coaccess_tracker_unit_tb;
    import hctt_pkg::*;

    localparam int HOT_D   = 16;
    localparam int WARM_D  = 64;
    localparam int SLOT_D  = 32;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    hctt_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    hctt_out_t out_data;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hot_cold_tier_coaccess_tracker_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // tracker mirror
    logic [15:0] p_acc, p_reb, p_dem, p_age;
    logic [7:0]  p_hint;
    logic [31:0] turn_ctr;
    logic [31:0] ring [RING_LEN];
    int          ring_ptr;
    logic [31:0] hot_id [HOT_D];
    logic [15:0] hot_cnt [HOT_D];
    logic [31:0] hot_turn [HOT_D];
    int          hot_n;
    logic [31:0] warm_id [WARM_D];
    logic [15:0] warm_cnt [WARM_D];
    logic [31:0] warm_turn [WARM_D];
    int          warm_n;
    logic [31:0] slot_id [SLOT_D];
    int          slot_n;
    logic [7:0]  pairs [SLOT_D*SLOT_D];

    hctt_in_t  cmd_q [$];
    hctt_out_t result_q [$];
    int        errors;
    int        results_seen;
    int        cycles;
    int        send_idle_pct;
    int        stall_pct;
    logic      cfg_busy;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("hot_cold_tier_coaccess_tracker_unit test failed");
            $finish;
        end
    end

    function automatic int find_hot(logic [31:0] id);
        for (int i = 0; i < hot_n; i++)
            if (hot_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int find_warm(logic [31:0] id);
        for (int i = 0; i < warm_n; i++)
            if (warm_id[i] == id) return i;
        return -1;
    endfunction

    function automatic logic [1:0] tier_of(logic [31:0] id);
        if (find_hot(id) >= 0) return TIER_HOT;
        if (find_warm(id) >= 0) return TIER_WARM;
        return TIER_NONE;
    endfunction

    task automatic tracker_reset();
        p_acc = 16'd5; p_reb = 16'd10; p_dem = 16'd3; p_age = 16'd100; p_hint = 8'd2;
        turn_ctr = '0; ring_ptr = 0; hot_n = 0; warm_n = 0; slot_n = 0;
        for (int i = 0; i < RING_LEN; i++) ring[i] = '0;
        for (int i = 0; i < SLOT_D*SLOT_D; i++) pairs[i] = '0;
    endtask

    task automatic pair_bump(logic [31:0] a, logic [31:0] b);
        int sa, sb;
        sa = -1; sb = -1;
        for (int i = 0; i < slot_n; i++)
        begin
            if (slot_id[i] == a) sa = i;
            if (slot_id[i] == b) sb = i;
        end
        if (sa < 0 && slot_n < SLOT_D) begin sa = slot_n; slot_id[slot_n] = a; slot_n++; end
        if (sb < 0 && slot_n < SLOT_D) begin sb = slot_n; slot_id[slot_n] = b; slot_n++; end
        if (sa >= 0 && sb >= 0)
        begin
            if (pairs[sa*SLOT_D+sb] != 8'hFF) pairs[sa*SLOT_D+sb]++;
            if (pairs[sb*SLOT_D+sa] != 8'hFF) pairs[sb*SLOT_D+sa]++;
        end
    endtask

    task automatic move_warm_to_hot(int i);
        hot_id[hot_n] = warm_id[i]; hot_cnt[hot_n] = warm_cnt[i];
        hot_turn[hot_n] = warm_turn[i]; hot_n++;
        warm_n--;
        warm_id[i] = warm_id[warm_n]; warm_cnt[i] = warm_cnt[warm_n];
        warm_turn[i] = warm_turn[warm_n];
    endtask

    task automatic track_access(logic [31:0] id);
        int h, w;
        turn_ctr++;
        ring[ring_ptr] = id;
        ring_ptr = (ring_ptr + 1) % RING_LEN;
        for (int i = 0; i < RING_LEN; i++)
            if (ring[i] != 0 && ring[i] != id) pair_bump(id, ring[i]);
        h = find_hot(id);
        if (h >= 0)
        begin
            if (hot_cnt[h] != 16'hFFFF) hot_cnt[h]++;
            hot_turn[h] = turn_ctr;
            return;
        end
        w = find_warm(id);
        if (w >= 0)
        begin
            if (warm_cnt[w] != 16'hFFFF) warm_cnt[w]++;
            warm_turn[w] = turn_ctr;
            if (warm_cnt[w] > p_acc && hot_n < HOT_D) move_warm_to_hot(w);
            return;
        end
        if (warm_n < WARM_D)
        begin
            warm_id[warm_n] = id; warm_cnt[warm_n] = 16'd1;
            warm_turn[warm_n] = turn_ctr; warm_n++;
        end
    endtask

    task automatic track_rebalance();
        logic [31:0] lim;
        lim = (turn_ctr > 32'(p_age)) ? turn_ctr - 32'(p_age) : '0;
        for (int i = hot_n - 1; i >= 0; i--)
            if (hot_turn[i] < lim && hot_cnt[i] < p_dem)
            begin
                if (warm_n < WARM_D)
                begin
                    warm_id[warm_n] = hot_id[i]; warm_cnt[warm_n] = hot_cnt[i];
                    warm_turn[warm_n] = hot_turn[i]; warm_n++;
                end
                hot_n--;
                hot_id[i] = hot_id[hot_n]; hot_cnt[i] = hot_cnt[hot_n];
                hot_turn[i] = hot_turn[hot_n];
            end
        for (int i = warm_n - 1; i >= 0; i--)
            if (warm_cnt[i] > p_reb && hot_n < HOT_D) move_warm_to_hot(i);
        for (int i = 0; i < warm_n; i++)
            if (warm_turn[i] < lim) warm_cnt[i] = 16'((32'(warm_cnt[i]) * 3) / 4);
    endtask

    // computes the results of one command and queues them
    task automatic predict_results(hctt_in_t c);
        hctt_out_t r;
        logic [31:0] hint [HINT_MAX];
        logic [1:0] t;
        int n, slot, best, bi;
        logic found, dup;
        r = '0;
        r.last = 1'b1;
        if (c.cmd == CMD_ACCESS)
        begin
            track_access(c.item_id);
            r.tier = tier_of(c.item_id);
            result_q.push_back(r);
            return;
        end
        if (c.cmd == CMD_REBALANCE)
        begin
            track_rebalance();
            result_q.push_back(r);
            return;
        end
        t = tier_of(c.item_id);
        n = 0; slot = 0; found = 1'b0;
        for (int i = 0; i < slot_n; i++)
            if (!found && slot_id[i] == c.item_id) begin slot = i; found = 1'b1; end
        while (found && n < HINT_MAX)
        begin
            best = 0; bi = -1;
            for (int j = 0; j < slot_n; j++)
            begin
                if (j == slot || pairs[slot*SLOT_D+j] <= best) continue;
                dup = 1'b0;
                for (int k = 0; k < n; k++) if (hint[k] == slot_id[j]) dup = 1'b1;
                if (!dup) begin best = pairs[slot*SLOT_D+j]; bi = j; end
            end
            if (bi < 0 || best <= p_hint) break;
            hint[n] = slot_id[bi];
            n++;
        end
        r.tier = t;
        if (n == 0)
        begin
            result_q.push_back(r);
            return;
        end
        for (int k = 0; k < n; k++)
        begin
            r.hint_valid = 1'b1;
            r.hint_id = hint[k];
            r.last = (k == n - 1);
            result_q.push_back(r);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid) predict_results(in_data);
            if (cmd_q.size() > 0 && !cfg_busy && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= cmd_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (result_q.size() == 0)
                begin
                    $display("unexpected result %0h", out_data);
                    errors++;
                end
                else
                begin
                    hctt_out_t e;
                    e = result_q.pop_front();
                    if (out_data.tier != e.tier)
                        report("tier", 32'(out_data.tier), 32'(e.tier));
                    if (out_data.hint_valid != e.hint_valid)
                        report("hint_valid", 32'(out_data.hint_valid), 32'(e.hint_valid));
                    if (out_data.hint_id != e.hint_id)
                        report("hint_id", out_data.hint_id, e.hint_id);
                    if (out_data.last != e.last)
                        report("last", 32'(out_data.last), 32'(e.last));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic hctt_in_t mk(logic [1:0] c, logic [31:0] id);
        hctt_in_t x;
        x.cmd = c;
        x.item_id = id;
        return x;
    endfunction

    task automatic wait_drained();
        while (cmd_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // one write, with cfg_we dropped again before returning so back-to-back writes never collide
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PROMOTE_ACCESS:    p_acc = val;
            CFG_PROMOTE_REBALANCE: p_reb = val;
            CFG_DEMOTE_LIMIT:      p_dem = val;
            CFG_AGE_WINDOW:        p_age = val;
            default:               p_hint = val[7:0];
        endcase
    endtask

    // mostly a small pool of ids so counts, pairs and promotions build up
    task automatic add_random(int count);
        logic [31:0] pool [12];
        int r;
        for (int i = 0; i < 12; i++) pool[i] = $urandom_range(40);
        pool[0] = 32'hFFFF_FFFF;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 55) cmd_q.push_back(mk(CMD_ACCESS, pool[$urandom_range(11)]));
            else if (r < 62) cmd_q.push_back(mk(CMD_ACCESS, $urandom()));
            else if (r < 72) cmd_q.push_back(mk(CMD_REBALANCE, $urandom()));
            else if (r < 95) cmd_q.push_back(mk(CMD_QUERY, pool[$urandom_range(11)]));
            else cmd_q.push_back(mk(CMD_UNKNOWN, $urandom()));
        end
    endtask

    initial
    begin
        cycles = 0; errors = 0; results_seen = 0;
        send_idle_pct = 0; stall_pct = 0;
        cfg_busy = 1'b1;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        tracker_reset();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(CFG_HINT_MINIMUM, 16'd1);
        cfg_busy = 1'b0;

        // directed: extremes, id zero, duplicates in the ring, every command
        cmd_q.push_back(mk(CMD_QUERY, 32'd7));
        cmd_q.push_back(mk(CMD_ACCESS, 32'd0));
        cmd_q.push_back(mk(CMD_ACCESS, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(CMD_ACCESS, 32'd7));
        cmd_q.push_back(mk(CMD_ACCESS, 32'd7));
        cmd_q.push_back(mk(CMD_ACCESS, 32'hFFFF_FFFF));
        for (int i = 0; i < 3; i++)
        begin
            cmd_q.push_back(mk(CMD_ACCESS, 32'd9));
            cmd_q.push_back(mk(CMD_ACCESS, 32'd7));
            cmd_q.push_back(mk(CMD_ACCESS, 32'h5555_AAAA));
        end
        cmd_q.push_back(mk(CMD_QUERY, 32'd7));
        cmd_q.push_back(mk(CMD_UNKNOWN, 32'd9));
        cmd_q.push_back(mk(CMD_QUERY, 32'd0));
        cmd_q.push_back(mk(CMD_REBALANCE, 32'hAAAA_5555));
        cmd_q.push_back(mk(CMD_QUERY, 32'hFFFF_FFFF));
        wait_drained();

        // phases: settings changed between them while idle
        for (int ph = 0; ph < 5; ph++)
        begin
            cfg_busy = 1'b1;
            case (ph)
                0: begin write_reg(CFG_PROMOTE_ACCESS, 16'd0); write_reg(CFG_AGE_WINDOW, 16'd0);
                         write_reg(CFG_DEMOTE_LIMIT, 16'hFFFF); end
                1: begin write_reg(CFG_PROMOTE_ACCESS, 16'hFFFF);
                         write_reg(CFG_PROMOTE_REBALANCE, 16'd0);
                         write_reg(CFG_HINT_MINIMUM, 16'd0); send_idle_pct = 81; end
                2: begin write_reg(CFG_PROMOTE_REBALANCE, 16'hFFFF);
                         write_reg(CFG_AGE_WINDOW, 16'hFFFF); write_reg(CFG_DEMOTE_LIMIT, 16'd0);
                         write_reg(CFG_HINT_MINIMUM, 16'd255);
                         send_idle_pct = 0; stall_pct = 81; end
                3: begin write_reg(CFG_PROMOTE_ACCESS, 16'd3); write_reg(CFG_PROMOTE_REBALANCE, 16'd4);
                         write_reg(CFG_DEMOTE_LIMIT, 16'd5); write_reg(CFG_AGE_WINDOW, 16'd6);
                         write_reg(CFG_HINT_MINIMUM, 16'd2);
                         send_idle_pct = 38; stall_pct = 38; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            cfg_busy = 1'b0;
            add_random(18);
            wait_drained();
        end

        $display("ran directed and random access/rebalance/query commands over 5 setting phases");
        $display("%0d results checked, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("hot_cold_tier_coaccess_tracker_unit test passed");
        else
            $display("hot_cold_tier_coaccess_tracker_unit test failed");
        $finish;
    end
endmodule
